/* hw/rtl/ngse_pkg.sv */
// ----------------------------------------------------------------------------
// ngse_pkg
// Shared types, codes and constants of the n-body gravity step engine.
// ----------------------------------------------------------------------------
package ngse_pkg;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_STEP  = 2'd1;
  localparam logic [1:0] KIND_BLAST = 2'd2;

  localparam logic [1:0] CFG_BODY_COUNT = 2'd0;
  localparam logic [1:0] CFG_GRAV_STR   = 2'd1;
  localparam logic [1:0] CFG_GRAV_EN    = 2'd2;

  localparam logic [15:0] GRAV_STR_RESET = 16'd3000;
  localparam logic [32:0] ONE_Q16        = 33'd65536;
  // 200 in Q16.16
  localparam logic [23:0] BLAST_SCALE    = 24'd13107200;

  typedef struct packed {
    logic [1:0]         kind;
    logic [5:0]         body_index;
    logic signed [31:0] load_pos_x;
    logic signed [31:0] load_pos_y;
    logic signed [31:0] load_vel_x;
    logic signed [31:0] load_vel_y;
    logic [15:0]        load_mass;
    logic [15:0]        time_delta;
    logic signed [31:0] blast_x;
    logic signed [31:0] blast_y;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         out_index;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic               last;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_RD, OP_DIFF_G, OP_DIFF_B, OP_SQX, OP_SQY, OP_SQRT_GO,
    OP_DIST, OP_DIV_S1, OP_DIV_S2, OP_DIV_UX, OP_DIV_UY, OP_DIV_BX, OP_DIV_BY,
    OP_Q_S, OP_Q_UX, OP_Q_UY, OP_AMUL, OP_DVMUL, OP_VLOAD, OP_VADD_G,
    OP_VADD_B, OP_VWRITE, OP_DMUL, OP_DADD, OP_BMUL
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   last;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
  } stat_t;

endpackage

/* hw/rtl/ngse_sqrt.sv */
// ----------------------------------------------------------------------------
// ngse_sqrt
// Iterative floor square root of a 64-bit value, two radicand bits a cycle.
// ----------------------------------------------------------------------------
module ngse_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [63:0] x_r;
  logic [32:0] rem_r;
  logic [31:0] root_r;
  logic [34:0] trial_num;
  logic [34:0] trial_den;

  assign trial_num = {rem_r, x_r[63:62]};
  assign trial_den = {1'b0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        x_r    <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        x_r   <= {x_r[61:0], 2'b00};
        cnt_r <= cnt_r + 5'd1;
        if (trial_num >= trial_den) begin
          rem_r  <= 33'(trial_num - trial_den);
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          rem_r  <= trial_num[32:0];
          root_r <= {root_r[30:0], 1'b0};
        end
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

/* hw/rtl/ngse_div.sv */
// ----------------------------------------------------------------------------
// ngse_div
// Restoring divider, 56-bit dividend by 33-bit divisor, 32-bit quotient,
// one quotient bit a cycle. The quotient must fit 32 bits.
// ----------------------------------------------------------------------------
module ngse_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [55:0] num,
  input  logic [32:0] den,
  output logic        done,
  output logic [31:0] quot
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [32:0] rem_r;
  logic [31:0] lo_r;
  logic [32:0] den_r;
  logic [33:0] part;
  logic        fits;

  assign part = {rem_r, lo_r[31]};
  assign fits = part >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= {9'd0, num[55:32]};
        lo_r   <= num[31:0];
        den_r  <= den;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        rem_r <= fits ? 33'(part - {1'b0, den_r}) : part[32:0];
        lo_r  <= {lo_r[30:0], fits};
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = lo_r;

endmodule

/* hw/rtl/ngse_datapath.sv */
// ----------------------------------------------------------------------------
// ngse_datapath
// Body stores, pair arithmetic, shared square root and divider, result
// register. Executes one operation a cycle as commanded.
// ----------------------------------------------------------------------------
module ngse_datapath #(
  parameter int MAX_BODIES = 64,
  parameter int IW         = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_accept,
  input  ngse_pkg::in_item_t   in_data,
  input  logic [15:0]          gstrength,
  input  ngse_pkg::cmd_t       cmd,
  input  logic [IW-1:0]        addr_a,
  input  logic [IW-1:0]        addr_b,
  output ngse_pkg::stat_t      stat,
  output ngse_pkg::out_item_t  out_data
);

  import ngse_pkg::*;

  function automatic logic [31:0] sat33(input logic [32:0] v);
    if (v[32] != v[31]) return v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return v[31:0];
  endfunction

  function automatic logic [31:0] sat34(input logic [33:0] v);
    if ((v[33] != v[32]) || (v[32] != v[31])) return v[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return v[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? 32'(~v + 32'd1) : v;
  endfunction

  function automatic logic [33:0] signed_add(input logic [31:0] a, input logic neg,
                                             input logic [31:0] m);
    logic [33:0] sm;
    sm = neg ? 34'(34'd0 - {2'b00, m}) : {2'b00, m};
    return 34'({{2{a[31]}}, a} + sm);
  endfunction

  logic [31:0] pos_x_mem [0:MAX_BODIES-1];
  logic [31:0] pos_y_mem [0:MAX_BODIES-1];
  logic [31:0] vel_x_mem [0:MAX_BODIES-1];
  logic [31:0] vel_y_mem [0:MAX_BODIES-1];
  logic [15:0] mass_mem  [0:MAX_BODIES-1];

  in_item_t    item_r;
  out_item_t   out_r;
  logic [31:0] rd_pxa_r, rd_pya_r, rd_vxa_r, rd_vya_r, rd_pxb_r, rd_pyb_r;
  logic [15:0] rd_mb_r;
  logic        neg_x_r, neg_y_r;
  logic [31:0] mx_r, my_r, gm_r, s_r, ux_r, uy_r, ax_r, ay_r, dvx_r, dvy_r;
  logic [31:0] vacc_x_r, vacc_y_r;
  logic [63:0] sum_r;
  logic [32:0] d_r;
  logic [55:0] bnx_r, bny_r;

  logic        load_ok;
  logic        pos_we, vel_we;
  logic [IW-1:0] load_addr, pos_wa;
  logic [31:0] pos_wx, pos_wy, vel_wx, vel_wy, new_x, new_y;
  logic [31:0] sub_a_x, sub_b_x, sub_a_y, sub_b_y, dxs, dys;
  logic [47:0] amx, amy, dmx, dmy, drx, dry;
  logic        div_start, sqrt_start;
  logic [55:0] div_num;
  logic [31:0] quot, root;
  logic        div_done, sqrt_done;

  assign load_ok   = (cmd.op == OP_LOAD) && (int'(item_r.body_index) < MAX_BODIES);
  assign load_addr = IW'(item_r.body_index);

  always_comb begin
    if (cmd.op == OP_DIFF_B) begin
      sub_a_x = rd_pxa_r;
      sub_b_x = item_r.blast_x;
      sub_a_y = rd_pya_r;
      sub_b_y = item_r.blast_y;
    end else begin
      sub_a_x = rd_pxb_r;
      sub_b_x = rd_pxa_r;
      sub_a_y = rd_pyb_r;
      sub_b_y = rd_pya_r;
    end
  end

  assign dxs = sat33(33'({sub_a_x[31], sub_a_x} - {sub_b_x[31], sub_b_x}));
  assign dys = sat33(33'({sub_a_y[31], sub_a_y} - {sub_b_y[31], sub_b_y}));

  assign amx = 48'(ux_r[15:0]) * 48'(s_r);
  assign amy = 48'(uy_r[15:0]) * 48'(s_r);
  assign dmx = 48'(ax_r) * 48'(item_r.time_delta);
  assign dmy = 48'(ay_r) * 48'(item_r.time_delta);
  assign drx = 48'(mag32(rd_vxa_r)) * 48'(item_r.time_delta);
  assign dry = 48'(mag32(rd_vya_r)) * 48'(item_r.time_delta);

  assign new_x = sat34(signed_add(rd_pxa_r, neg_x_r, dvx_r));
  assign new_y = sat34(signed_add(rd_pya_r, neg_y_r, dvy_r));

  always_comb begin
    div_start = 1'b1;
    case (cmd.op)
      OP_DIV_S1: div_num = {8'd0, gm_r, 16'd0};
      OP_DIV_S2: div_num = {8'd0, s_r, 16'd0};
      OP_DIV_UX: div_num = {8'd0, mx_r, 16'd0};
      OP_DIV_UY: div_num = {8'd0, my_r, 16'd0};
      OP_DIV_BX: div_num = bnx_r;
      OP_DIV_BY: div_num = bny_r;
      default: begin
        div_num   = bnx_r;
        div_start = 1'b0;
      end
    endcase
  end

  assign sqrt_start = (cmd.op == OP_SQRT_GO);

  assign pos_we = load_ok || (cmd.op == OP_DADD);
  assign pos_wa = load_ok ? load_addr : addr_a;
  assign pos_wx = load_ok ? item_r.load_pos_x : new_x;
  assign pos_wy = load_ok ? item_r.load_pos_y : new_y;
  assign vel_we = load_ok || (cmd.op == OP_VWRITE);
  assign vel_wx = load_ok ? item_r.load_vel_x : vacc_x_r;
  assign vel_wy = load_ok ? item_r.load_vel_y : vacc_y_r;

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_x_mem[pos_wa] <= pos_wx;
      pos_y_mem[pos_wa] <= pos_wy;
    end
    if (vel_we) begin
      vel_x_mem[pos_wa] <= vel_wx;
      vel_y_mem[pos_wa] <= vel_wy;
    end
    if (load_ok) mass_mem[load_addr] <= item_r.load_mass;
    if (cmd.op == OP_RD) begin
      rd_pxa_r <= pos_x_mem[addr_a];
      rd_pya_r <= pos_y_mem[addr_a];
      rd_vxa_r <= vel_x_mem[addr_a];
      rd_vya_r <= vel_y_mem[addr_a];
      rd_pxb_r <= pos_x_mem[addr_b];
      rd_pyb_r <= pos_y_mem[addr_b];
      rd_mb_r  <= mass_mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) item_r <= in_data;
    unique case (cmd.op)
      OP_DIFF_G, OP_DIFF_B: begin
        neg_x_r <= dxs[31];
        neg_y_r <= dys[31];
        mx_r    <= mag32(dxs);
        my_r    <= mag32(dys);
        gm_r    <= 32'(gstrength) * 32'(rd_mb_r);
        if (cmd.op == OP_DIFF_B) begin
          vacc_x_r <= rd_vxa_r;
          vacc_y_r <= rd_vya_r;
        end
      end
      OP_SQX:   sum_r <= 64'(mx_r) * 64'(mx_r);
      OP_SQY:   sum_r <= sum_r + 64'(my_r) * 64'(my_r);
      OP_DIST:  d_r   <= 33'({1'b0, root} + ONE_Q16);
      OP_Q_S:   s_r   <= quot;
      OP_Q_UX:  ux_r  <= quot;
      OP_Q_UY:  uy_r  <= quot;
      OP_BMUL: begin
        bnx_r <= 56'(mx_r) * 56'(BLAST_SCALE);
        bny_r <= 56'(my_r) * 56'(BLAST_SCALE);
      end
      OP_AMUL: begin
        ax_r <= amx[47:16];
        ay_r <= amy[47:16];
      end
      OP_DVMUL: begin
        dvx_r <= dmx[47:16];
        dvy_r <= dmy[47:16];
      end
      OP_VLOAD: begin
        vacc_x_r <= rd_vxa_r;
        vacc_y_r <= rd_vya_r;
      end
      OP_VADD_G: begin
        vacc_x_r <= sat34(signed_add(vacc_x_r, neg_x_r, dvx_r));
        vacc_y_r <= sat34(signed_add(vacc_y_r, neg_y_r, dvy_r));
      end
      OP_VADD_B: begin
        vacc_x_r <= sat34(signed_add(vacc_x_r, neg_x_r, ux_r));
        vacc_y_r <= sat34(signed_add(vacc_y_r, neg_y_r, uy_r));
      end
      OP_DMUL: begin
        neg_x_r <= rd_vxa_r[31];
        neg_y_r <= rd_vya_r[31];
        dvx_r   <= drx[47:16];
        dvy_r   <= dry[47:16];
      end
      OP_DADD: begin
        out_r.out_index <= 6'(addr_a);
        out_r.new_pos_x <= new_x;
        out_r.new_pos_y <= new_y;
        out_r.last      <= cmd.last;
      end
      default: ;
    endcase
  end

  ngse_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sum_r),
    .done     (sqrt_done),
    .root     (root)
  );

  ngse_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (d_r),
    .done  (div_done),
    .quot  (quot)
  );

  assign stat.sqrt_done = sqrt_done;
  assign stat.div_done  = div_done;
  assign out_data       = out_r;

endmodule

/* hw/rtl/ngse_ctrl.sv */
// ----------------------------------------------------------------------------
// ngse_ctrl
// Sequencer: walks the body pairs, blast and drift passes and commands the
// datapath one operation a cycle outside its waits on square root and divider.
// ----------------------------------------------------------------------------
module ngse_ctrl #(
  parameter int MAX_BODIES = 64,
  parameter int IW         = 6,
  parameter int CW         = 7
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [1:0]      kind,
  input  logic [6:0]      body_count,
  input  logic            gravity_enabled,
  input  ngse_pkg::stat_t stat,
  output ngse_pkg::cmd_t  cmd,
  output logic [IW-1:0]   addr_a,
  output logic [IW-1:0]   addr_b,
  output logic            busy,
  output logic            out_valid
);

  import ngse_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE, S_LOAD, S_WAIT,
    S_G_VLD, S_G_VINIT, S_G_CHK, S_G_RD, S_G_DIFF,
    S_SQX, S_SQY, S_SQRT, S_DIST,
    S_G_DS1, S_G_QS1, S_G_DS2, S_G_QS2, S_G_DUX, S_G_QUX, S_G_DUY, S_G_QUY,
    S_G_AMUL, S_G_DV, S_G_VADD, S_G_VWR,
    S_B_RD, S_B_DIFF, S_B_MUL, S_B_DX, S_B_QX, S_B_DY, S_B_QY, S_B_VADD, S_B_VWR,
    S_D_RD, S_D_MUL, S_D_ADD
  } state_t;

  state_t        state_r, ret_r;
  logic [CW-1:0] i_r, j_r, n_r, n_w;
  logic          blast_r, out_valid_r, last_w;

  assign n_w    = (int'(body_count) > MAX_BODIES) ? CW'(MAX_BODIES) : CW'(body_count);
  assign last_w = (CW'(i_r + CW'(1)) == n_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      n_r         <= '0;
      blast_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            i_r     <= '0;
            j_r     <= '0;
            n_r     <= n_w;
            blast_r <= (kind == KIND_BLAST);
            unique case (kind)
              KIND_LOAD: state_r <= S_LOAD;
              KIND_STEP: begin
                if (n_w != '0) state_r <= gravity_enabled ? S_G_VLD : S_D_RD;
              end
              KIND_BLAST: begin
                if (n_w != '0) state_r <= S_B_RD;
              end
              default: ;
            endcase
          end
        end
        S_LOAD:    state_r <= S_IDLE;
        S_WAIT: begin
          if (stat.sqrt_done || stat.div_done) state_r <= ret_r;
        end
        S_G_VLD:   state_r <= S_G_VINIT;
        S_G_VINIT: begin
          j_r     <= '0;
          state_r <= S_G_CHK;
        end
        S_G_CHK: begin
          if (j_r == n_r) state_r <= S_G_VWR;
          else if (j_r == i_r) j_r <= j_r + CW'(1);
          else state_r <= S_G_RD;
        end
        S_G_RD:    state_r <= S_G_DIFF;
        S_G_DIFF:  state_r <= S_SQX;
        S_SQX:     state_r <= S_SQY;
        S_SQY:     state_r <= S_SQRT;
        S_SQRT: begin
          ret_r   <= S_DIST;
          state_r <= S_WAIT;
        end
        S_DIST:    state_r <= blast_r ? S_B_MUL : S_G_DS1;
        S_G_DS1: begin
          ret_r   <= S_G_QS1;
          state_r <= S_WAIT;
        end
        S_G_QS1:   state_r <= S_G_DS2;
        S_G_DS2: begin
          ret_r   <= S_G_QS2;
          state_r <= S_WAIT;
        end
        S_G_QS2:   state_r <= S_G_DUX;
        S_G_DUX: begin
          ret_r   <= S_G_QUX;
          state_r <= S_WAIT;
        end
        S_G_QUX:   state_r <= S_G_DUY;
        S_G_DUY: begin
          ret_r   <= S_G_QUY;
          state_r <= S_WAIT;
        end
        S_G_QUY:   state_r <= S_G_AMUL;
        S_G_AMUL:  state_r <= S_G_DV;
        S_G_DV:    state_r <= S_G_VADD;
        S_G_VADD: begin
          j_r     <= j_r + CW'(1);
          state_r <= S_G_CHK;
        end
        S_G_VWR: begin
          if (last_w) begin
            i_r     <= '0;
            state_r <= S_D_RD;
          end else begin
            i_r     <= i_r + CW'(1);
            state_r <= S_G_VLD;
          end
        end
        S_B_RD:    state_r <= S_B_DIFF;
        S_B_DIFF:  state_r <= S_SQX;
        S_B_MUL:   state_r <= S_B_DX;
        S_B_DX: begin
          ret_r   <= S_B_QX;
          state_r <= S_WAIT;
        end
        S_B_QX:    state_r <= S_B_DY;
        S_B_DY: begin
          ret_r   <= S_B_QY;
          state_r <= S_WAIT;
        end
        S_B_QY:    state_r <= S_B_VADD;
        S_B_VADD:  state_r <= S_B_VWR;
        S_B_VWR: begin
          if (last_w) state_r <= S_IDLE;
          else begin
            i_r     <= i_r + CW'(1);
            state_r <= S_B_RD;
          end
        end
        S_D_RD:    state_r <= S_D_MUL;
        S_D_MUL:   state_r <= S_D_ADD;
        S_D_ADD: begin
          out_valid_r <= 1'b1;
          if (last_w) state_r <= S_IDLE;
          else begin
            i_r     <= i_r + CW'(1);
            state_r <= S_D_RD;
          end
        end
        default:   state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.last = last_w;
    unique case (state_r)
      S_LOAD:                                  cmd.op = OP_LOAD;
      S_G_VLD, S_G_RD, S_B_RD, S_D_RD:         cmd.op = OP_RD;
      S_G_VINIT:                               cmd.op = OP_VLOAD;
      S_G_DIFF:                                cmd.op = OP_DIFF_G;
      S_B_DIFF:                                cmd.op = OP_DIFF_B;
      S_SQX:                                   cmd.op = OP_SQX;
      S_SQY:                                   cmd.op = OP_SQY;
      S_SQRT:                                  cmd.op = OP_SQRT_GO;
      S_DIST:                                  cmd.op = OP_DIST;
      S_G_DS1:                                 cmd.op = OP_DIV_S1;
      S_G_DS2:                                 cmd.op = OP_DIV_S2;
      S_G_DUX:                                 cmd.op = OP_DIV_UX;
      S_G_DUY:                                 cmd.op = OP_DIV_UY;
      S_B_DX:                                  cmd.op = OP_DIV_BX;
      S_B_DY:                                  cmd.op = OP_DIV_BY;
      S_G_QS1, S_G_QS2:                        cmd.op = OP_Q_S;
      S_G_QUX, S_B_QX:                         cmd.op = OP_Q_UX;
      S_G_QUY, S_B_QY:                         cmd.op = OP_Q_UY;
      S_G_AMUL:                                cmd.op = OP_AMUL;
      S_G_DV:                                  cmd.op = OP_DVMUL;
      S_G_VADD:                                cmd.op = OP_VADD_G;
      S_B_VADD:                                cmd.op = OP_VADD_B;
      S_G_VWR, S_B_VWR:                        cmd.op = OP_VWRITE;
      S_B_MUL:                                 cmd.op = OP_BMUL;
      S_D_MUL:                                 cmd.op = OP_DMUL;
      S_D_ADD:                                 cmd.op = OP_DADD;
      default:                                 cmd.op = OP_NONE;
    endcase
  end

  assign addr_a    = i_r[IW-1:0];
  assign addr_b    = j_r[IW-1:0];
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_out_from_drift: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == S_D_ADD))
    else $error("result strobe without a drift write");
  a_drift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_D_RD) |-> (i_r < n_r))
    else $error("drift index beyond body count");
  a_pair_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_G_RD) |-> ((j_r != i_r) && (j_r < n_r)))
    else $error("self pair or index beyond body count");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_D_ADD) && last_w) |=> ((state_r == S_IDLE) && out_valid_r))
    else $error("last result does not end the step");
`endif

endmodule

/* hw/rtl/nbody_gravity_step_engine_top.sv */
// ----------------------------------------------------------------------------
// nbody_gravity_step_engine_top
// Load: one body store write. Blast: per body in use, a square root and two
// divisions. Step: per ordered body pair when gravity is on, a square root and
// four divisions on the shared units, then a read, multiply and add per body
// for drift, one result strobe each; one item at a time, busy high throughout.
// Synchronous reset clears control and registers; body stores stay undefined.
// ----------------------------------------------------------------------------
module nbody_gravity_step_engine_top #(
  parameter int MAX_BODIES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ngse_pkg::in_item_t  in_data,
  output logic                out_valid,
  output ngse_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  import ngse_pkg::*;

  localparam int IW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int CW = $clog2(MAX_BODIES + 1);

  logic [6:0]    body_count_r;
  logic [15:0]   gstrength_r;
  logic          genable_r;
  cmd_t          cmd;
  stat_t         stat;
  logic [IW-1:0] addr_a, addr_b;
  logic          in_accept;

  assign in_accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_count_r <= '0;
      gstrength_r  <= GRAV_STR_RESET;
      genable_r    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BODY_COUNT: body_count_r <= cfg_data[6:0];
        CFG_GRAV_STR:   gstrength_r  <= cfg_data;
        CFG_GRAV_EN:    genable_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ngse_ctrl #(
    .MAX_BODIES (MAX_BODIES),
    .IW         (IW),
    .CW         (CW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .kind            (in_data.kind),
    .body_count      (body_count_r),
    .gravity_enabled (genable_r),
    .stat            (stat),
    .cmd             (cmd),
    .addr_a          (addr_a),
    .addr_b          (addr_b),
    .busy            (busy),
    .out_valid       (out_valid)
  );

  ngse_datapath #(
    .MAX_BODIES (MAX_BODIES),
    .IW         (IW)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_data   (in_data),
    .gstrength (gstrength_r),
    .cmd       (cmd),
    .addr_a    (addr_a),
    .addr_b    (addr_b),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

/* sim/nbody_gravity_step_engine_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbody_gravity_step_engine_checker
// Watches the item, result and register ports of the gravity step engine. It
// keeps its own copy of the body stores and registers, works out the position
// reports of every step item and compares them, in order, with the results.
// ----------------------------------------------------------------------------
module nbody_gravity_step_engine_checker
  import ngse_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  out_item_t out_data,
  input  logic      cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int        fail_count,
  output int        pending,
  output int        reports_seen
);

  localparam int NBODY = 64;

  longint    px [NBODY];
  longint    py [NBODY];
  longint    vx [NBODY];
  longint    vy [NBODY];
  bit [15:0] ms [NBODY];

  bit [6:0]  count_reg;
  bit [15:0] grav_reg;
  bit        grav_on;

  out_item_t report_q[$];

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic bit [63:0] magn(longint a);
    return a < 0 ? 64'd0 - a : a;
  endfunction

  function automatic longint scale_shift(longint a, bit [63:0] mul);
    bit [63:0] m;
    m = (magn(a) * mul) >> 16;
    return a < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint scale_div(longint a, bit [63:0] mul, bit [63:0] den);
    bit [63:0] m;
    m = (magn(a) * mul) / den;
    return a < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic bit [63:0] root_floor(bit [63:0] x);
    bit [63:0] res;
    bit [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic bit [63:0] soft_len(longint dx, longint dy);
    bit [63:0] mx;
    bit [63:0] my;
    mx = magn(dx);
    my = magn(dy);
    return root_floor(mx * mx + my * my) + 64'd65536;
  endfunction

  function automatic longint sext32(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  task automatic predict_item(in_item_t it);
    int n;
    longint dx, dy, ax, ay, bx, by;
    bit [63:0] d, s, dt;
    out_item_t r;
    n = (count_reg > NBODY) ? NBODY : count_reg;
    dt = 64'(it.time_delta);
    case (it.kind)
      KIND_LOAD: begin
        px[it.body_index] = sext32(it.load_pos_x);
        py[it.body_index] = sext32(it.load_pos_y);
        vx[it.body_index] = sext32(it.load_vel_x);
        vy[it.body_index] = sext32(it.load_vel_y);
        ms[it.body_index] = it.load_mass;
      end
      KIND_STEP: begin
        if (grav_on) begin
          for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
              if (i == j) continue;
              dx = clamp32(px[j] - px[i]);
              dy = clamp32(py[j] - py[i]);
              d = soft_len(dx, dy);
              s = (64'(grav_reg) * 64'(ms[j]) * 64'd65536) / d;
              s = (s * 64'd65536) / d;
              ax = scale_shift(scale_div(dx, 64'd65536, d), s);
              ay = scale_shift(scale_div(dy, 64'd65536, d), s);
              vx[i] = clamp32(vx[i] + scale_shift(ax, dt));
              vy[i] = clamp32(vy[i] + scale_shift(ay, dt));
            end
          end
        end
        for (int i = 0; i < n; i++) begin
          px[i] = clamp32(px[i] + scale_shift(vx[i], dt));
          py[i] = clamp32(py[i] + scale_shift(vy[i], dt));
          r.out_index = i[5:0];
          r.new_pos_x = px[i][31:0];
          r.new_pos_y = py[i][31:0];
          r.last = (i + 1 == n);
          report_q = {report_q, r};
        end
      end
      KIND_BLAST: begin
        bx = sext32(it.blast_x);
        by = sext32(it.blast_y);
        for (int i = 0; i < n; i++) begin
          dx = clamp32(px[i] - bx);
          dy = clamp32(py[i] - by);
          d = soft_len(dx, dy);
          vx[i] = clamp32(vx[i] + scale_div(dx, 64'd13107200, d));
          vy[i] = clamp32(vy[i] + scale_div(dy, 64'd13107200, d));
        end
      end
      default: ;
    endcase
  endtask

  initial begin
    fail_count = 0;
    reports_seen = 0;
    for (int i = 0; i < NBODY; i++) begin
      px[i] = 0; py[i] = 0; vx[i] = 0; vy[i] = 0; ms[i] = 0;
    end
  end

  assign pending = report_q.size();

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      count_reg <= 0;
      grav_reg <= GRAV_STR_RESET;
      grav_on <= 1'b1;
      report_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BODY_COUNT: count_reg <= cfg_data[6:0];
          CFG_GRAV_STR:   grav_reg <= cfg_data;
          CFG_GRAV_EN:    grav_on <= cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) predict_item(in_data);
      if (out_valid) begin
        reports_seen++;
        if (report_q.size() == 0) begin
          $error("unexpected report, index %0d", out_data.out_index);
          fail_count++;
        end else begin
          e = report_q.pop_front();
          if (out_data.out_index !== e.out_index) begin
            $error("out_index: expected %0d, got %0d", e.out_index, out_data.out_index);
            fail_count++;
          end
          if (out_data.new_pos_x !== e.new_pos_x) begin
            $error("new_pos_x: expected %0d, got %0d", e.new_pos_x, out_data.new_pos_x);
            fail_count++;
          end
          if (out_data.new_pos_y !== e.new_pos_y) begin
            $error("new_pos_y: expected %0d, got %0d", e.new_pos_y, out_data.new_pos_y);
            fail_count++;
          end
          if (out_data.last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, out_data.last);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

/* sim/nbody_gravity_step_engine_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbody_gravity_step_engine_top_test
// Drives load, step, blast and unknown items into the gravity step engine with
// random gaps, across several register settings, and leaves the checking of
// the position reports to the checker beside it.
// ----------------------------------------------------------------------------
module nbody_gravity_step_engine_top_test;
  import ngse_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_data = '0;
  logic        out_valid;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_BODY_COUNT;
  logic [15:0] cfg_data = '0;

  int fail_count, pending, reports_seen;
  int items_sent = 0;
  int cycles = 0;
  bit gaps_on = 1'b1;

  always #10 clk = ~clk;

  nbody_gravity_step_engine_top i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  nbody_gravity_step_engine_checker i_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .reports_seen(reports_seen)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // mostly modest coordinates so bodies interact; sometimes full range
  function automatic logic [31:0] rand_q16();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = gaps_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (busy || pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t body_load(int k, logic [31:0] x, logic [31:0] y,
                                         logic [31:0] u, logic [31:0] v,
                                         logic [15:0] m);
    in_item_t it;
    it = '0;
    it.kind = KIND_LOAD;
    it.body_index = k[5:0];
    it.load_pos_x = x; it.load_pos_y = y;
    it.load_vel_x = u; it.load_vel_y = v;
    it.load_mass = m;
    return it;
  endfunction

  function automatic in_item_t random_item(bit loads_ok);
    in_item_t it;
    int pick;
    logic [255:0] raw;
    it = '0;
    it.time_delta = 16'($urandom);
    it.blast_x = rand_q16();
    it.blast_y = rand_q16();
    pick = $urandom_range(0, 9);
    if (pick < 3 && loads_ok) begin
      it = body_load($urandom_range(0, 63), rand_q16(), rand_q16(), rand_q16(),
                     rand_q16(), 16'($urandom));
    end else if (pick < 7) begin
      it.kind = KIND_STEP;
    end else if (pick < 9) begin
      it.kind = KIND_BLAST;
    end else begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom};
      it = raw[$bits(in_item_t)-1:0];
      it.kind = KIND_UNKNOWN;
    end
    return it;
  endfunction

  initial begin
    in_item_t it;
    int counts [6] = '{2, 3, 5, 8, 1, 4};
    int gs     [6] = '{3000, 65535, 0, 1, 40000, 12345};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, coincident pair, zero and full mass
    send_item(body_load(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h8000_0000, 16'hFFFF));
    send_item(body_load(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h7FFF_FFFF, 16'hFFFF));
    send_item(body_load(2, 32'h0001_0000, 32'h0001_0000, 0, 0, 16'd0));
    send_item(body_load(3, 32'h0001_0000, 32'h0001_0000, 32'h0000_8000,
                        32'hFFFF_8000, 16'd100));
    it = '0;
    it.kind = KIND_STEP;
    it.time_delta = 16'hFFFF;
    send_item(it);
    write_reg(CFG_BODY_COUNT, 16'd4);
    send_item(it);
    it.time_delta = 16'd0;
    send_item(it);
    it.time_delta = 16'd1;
    send_item(it);
    it.kind = KIND_BLAST;
    it.blast_x = 32'h7FFF_FFFF; it.blast_y = 32'h8000_0000;
    send_item(it);
    it.blast_x = 32'h0001_0000; it.blast_y = 32'h0001_0000;
    send_item(it);
    it = '1;
    it.kind = KIND_UNKNOWN;
    send_item(it);
    it = '0;
    it.kind = KIND_STEP;
    it.time_delta = 16'h8000;
    send_item(it);

    // every slot gets written before larger counts read it
    for (int k = 4; k < 64; k++)
      send_item(body_load(k, rand_q16(), rand_q16(), rand_q16(), rand_q16(),
                          16'($urandom)));

    write_reg(CFG_GRAV_EN, 16'd0);
    write_reg(CFG_BODY_COUNT, 16'd64);
    for (int i = 0; i < 6; i++) send_item(random_item(1'b1));
    write_reg(CFG_BODY_COUNT, 16'd127);
    for (int i = 0; i < 6; i++) send_item(random_item(1'b1));
    write_reg(CFG_BODY_COUNT, 16'd0);
    for (int i = 0; i < 4; i++) send_item(random_item(1'b1));
    write_reg(CFG_GRAV_EN, 16'd1);

    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_BODY_COUNT, 16'(counts[p]));
      write_reg(CFG_GRAV_STR, 16'(gs[p]));
      gaps_on = (p % 3) != 2;
      for (int i = 0; i < 9; i++) send_item(random_item(1'b1));
    end

    drain();
    repeat (200) @(posedge clk);
    $display("ran %0d items over body counts 0 to 127 with gravity on and off,",
             items_sent);
    $display("and checked %0d position reports", reports_seen);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* nbody_gravity_step_engine_top.f */
hw/rtl/ngse_pkg.sv
hw/rtl/ngse_sqrt.sv
hw/rtl/ngse_div.sv
hw/rtl/ngse_datapath.sv
hw/rtl/ngse_ctrl.sv
hw/rtl/nbody_gravity_step_engine_top.sv
sim/nbody_gravity_step_engine_checker.sv
sim/nbody_gravity_step_engine_top_test.sv
